[sv/storage_aware_route_selector_core_assert.svh]
// assertion macros for the route selector core
`ifndef STORAGE_AWARE_ROUTE_SELECTOR_CORE_ASSERT_SVH
`define STORAGE_AWARE_ROUTE_SELECTOR_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define SARS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication
`define SARS_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

[sv/sars_pkg.sv]
// ----------------------------------------------------------------------------
// sars_pkg
// shared types and constants of the route selector core
// ----------------------------------------------------------------------------
package sars_pkg;
    localparam int NODES = 64;
    localparam int ID_W = $clog2(NODES);
    localparam int MAX_CAND = 16;
    localparam int CAND_W = $clog2(MAX_CAND);
    localparam int ENT_W = 49; // known, belief, usage, capacity

    localparam logic [2:0] K_CAP = 3'd0;
    localparam logic [2:0] K_HELLO = 3'd1;
    localparam logic [2:0] K_OWN = 3'd2;
    localparam logic [2:0] K_MERGE = 3'd3;
    localparam logic [2:0] K_COMMIT = 3'd4;
    localparam logic [2:0] K_RELEASE = 3'd5;
    localparam logic [2:0] K_SCORE = 3'd6;
    localparam logic [2:0] K_READ = 3'd7;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_AGE_RD, S_AGE_WAIT, S_AGE_WR, S_RD, S_WAIT,
        S_MUL, S_DIV, S_WR, S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  node_id;
        logic [15:0] amount;
        logic [15:0] neighbor_belief;
        logic [31:0] now_time;
        logic        path_end;
        logic        final_candidate;
    } t_in;

    typedef struct packed {
        logic        entry_known;
        logic [15:0] entry_belief;
        logic [15:0] entry_usage;
        logic [3:0]  chosen_index;
        logic [16:0] chosen_score;
        logic        is_score;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic        load;      // capture input beat
        logic        age_chk;   // compute aging decision
        logic        addr_sel;  // 1 sweep address, 0 item address
        logic        clr_wr;    // write zero at sweep address
        logic        age_wr;    // write aged entry
        logic        rd;        // issue read
        logic        mul;       // form merge products
        logic        div_start;
        logic        item_wr;   // write item result
        logic        score;     // update score state
        logic        sweep_inc;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic age_due;
        logic sweep_last;
        logic need_div;
        logic div_done;
        logic emits;
    } t_sts;
endpackage

[sv/sars_if.sv]
// ----------------------------------------------------------------------------
// sars_in_if / sars_out_if
// valid/ready channels of the route selector core
// ----------------------------------------------------------------------------
interface sars_in_if;
    logic            valid;
    logic            ready;
    sars_pkg::t_in   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sars_out_if;
    logic            valid;
    logic            ready;
    sars_pkg::t_out  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/storage_aware_route_selector_core.sv]
// ----------------------------------------------------------------------------
// storage_aware_route_selector_core
// per-node capacity/belief/use table with bottleneck path selection
// ----------------------------------------------------------------------------
// usage notes
//   in channel: one beat per item (kind, node_id, amount, ...)
//   out channel: one beat for a read, or for the last node of the final
//     candidate of a score run; other items give no beat
//   cfg port: i_cfg_we/i_cfg_wdata write the belief aging interval
//   sequence: an item passes S_AGE_RD, S_RD, S_WAIT, S_MUL, S_DIV, S_WR
//     and S_OUT; a merge of a known entry with a nonzero belief sum also
//     waits on the divider (one quotient bit a cycle), and aging adds
//     S_AGE_WAIT and S_AGE_WR per table entry (single-port table memory)
//   one item is in flight at a time; the next beat is taken once the
//     previous result has been handed to the output register
//   reset: after i_rst_n the table is cleared by a pass over all 64
//     entries, in ready stays low during it
//   receiver stall: the result holds in the output register and the
//     input stops accepting while a result is pending
// ----------------------------------------------------------------------------
`include "storage_aware_route_selector_core_assert.svh"

module storage_aware_route_selector_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sars_in_if.sink       i_in,
    sars_out_if.source    o_out,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata
);
    logic [31:0] r_age_interval;
    sars_pkg::t_cmd cmd;
    sars_pkg::t_sts sts;
    sars_pkg::t_out res;
    logic out_load;
    logic r_out_valid;
    sars_pkg::t_out r_out_data;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_interval <= 32'd100;
        end else if (i_cfg_we) begin
            r_age_interval <= i_cfg_wdata;
        end
    end

    sars_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_out_free (!r_out_valid || o_out.ready),
        .o_out_load (out_load),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sars_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_data         (i_in.data),
        .i_age_interval (r_age_interval),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_res          (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= res.is_score
                ? {1'b0, 16'd0, 16'd0, res.chosen_index, res.chosen_score, 1'b1}
                : {res.entry_known, res.entry_belief, res.entry_usage, 4'd0, 17'd0, 1'b0};
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out_data;

    // a result is never loaded over one still waiting
    `SARS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, out_load, !r_out_valid || o_out.ready)
    // input never taken while divider busy
    `SARS_ASSERT_IMP(a_idle_accept, i_clk, i_rst_n, i_in.ready, sts.div_done)
    // an accepted beat gives no result in the next cycle
    `SARS_ASSERT_NXT(a_no_early_out, i_clk, i_rst_n, i_in.valid && i_in.ready, !out_load)
endmodule

[sv/sars_ram.sv]
// ----------------------------------------------------------------------------
// sars_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
module sars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[sv/sars_ctrl.sv]
// ----------------------------------------------------------------------------
// sars_ctrl
// sequencer for clearing, aging sweep, entry update and result handoff
// ----------------------------------------------------------------------------
module sars_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_free,
    output logic             o_out_load,
    input  sars_pkg::t_sts   i_sts,
    output sars_pkg::t_cmd   o_cmd
);
    sars_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sars_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            sars_pkg::S_CLEAR: begin
                o_cmd.addr_sel = 1'b1;
                o_cmd.clr_wr = 1'b1;
                o_cmd.sweep_inc = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = sars_pkg::S_IDLE;
                end
            end
            sars_pkg::S_IDLE: begin
                o_in_ready = i_out_free;
                if (i_in_valid && i_out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = sars_pkg::S_AGE_RD;
                end
            end
            sars_pkg::S_AGE_RD: begin
                o_cmd.age_chk = 1'b1;
                o_cmd.addr_sel = 1'b1;
                o_cmd.rd = 1'b1;
                n_state = i_sts.age_due ? sars_pkg::S_AGE_WAIT : sars_pkg::S_RD;
            end
            sars_pkg::S_AGE_WAIT: begin
                o_cmd.addr_sel = 1'b1;
                n_state = sars_pkg::S_AGE_WR;
            end
            sars_pkg::S_AGE_WR: begin
                o_cmd.addr_sel = 1'b1;
                o_cmd.age_wr = 1'b1;
                o_cmd.sweep_inc = 1'b1;
                n_state = i_sts.sweep_last ? sars_pkg::S_RD : sars_pkg::S_AGE_WAIT;
            end
            sars_pkg::S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = sars_pkg::S_WAIT;
            end
            sars_pkg::S_WAIT: begin
                n_state = sars_pkg::S_MUL;
            end
            sars_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = sars_pkg::S_DIV;
            end
            sars_pkg::S_DIV: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = sars_pkg::S_WR;
                end else begin
                    n_state = sars_pkg::S_WR;
                end
            end
            sars_pkg::S_WR: begin
                if (i_sts.div_done) begin
                    o_cmd.item_wr = 1'b1;
                    o_cmd.score = 1'b1;
                    n_state = sars_pkg::S_OUT;
                end
            end
            sars_pkg::S_OUT: begin
                o_out_load = i_sts.emits;
                n_state = sars_pkg::S_IDLE;
            end
            default: n_state = sars_pkg::S_IDLE;
        endcase
    end
endmodule

[sv/sars_dp.sv]
// ----------------------------------------------------------------------------
// sars_dp
// table memory, aging, merge divider and path scoring
// ----------------------------------------------------------------------------
module sars_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sars_pkg::t_in    i_data,
    input  logic [31:0]      i_age_interval,
    input  sars_pkg::t_cmd   i_cmd,
    output sars_pkg::t_sts   o_sts,
    output sars_pkg::t_out   o_res
);
    sars_pkg::t_in r_item;
    logic [31:0] r_last_age;
    logic [sars_pkg::ID_W-1:0] r_sweep;
    logic [sars_pkg::ID_W-1:0] addr;
    logic we;
    logic [sars_pkg::ENT_W-1:0] wdata, rdata;
    logic        e_known;
    logic [15:0] e_bel, e_use, e_cap;
    // merge
    logic [31:0] prod_a, prod_b;
    logic [32:0] r_num;
    logic [16:0] r_sum;
    logic [16:0] r_bsum;
    // divider
    logic [32:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic [33:0] trial;
    // scoring
    logic signed [17:0] r_pmin, r_best;
    logic [sars_pkg::CAND_W-1:0] r_bidx;
    logic [sars_pkg::CAND_W:0]   r_ccnt;
    logic signed [17:0] remain, pmin_n;
    logic        n_known;
    logic [15:0] n_bel, n_use, n_cap;
    logic [15:0] hello_use;
    // result of the item just written
    logic signed [17:0] r_fin_best;
    logic [sars_pkg::CAND_W-1:0] r_fin_idx;
    logic        r_ent_known;
    logic [15:0] r_ent_bel, r_ent_use;

    assign addr = i_cmd.addr_sel ? r_sweep : r_item.node_id;
    assign {e_known, e_bel, e_use, e_cap} = rdata;

    always_comb begin
        we = i_cmd.clr_wr | (i_cmd.age_wr) | i_cmd.item_wr;
        wdata = '0;
        if (i_cmd.age_wr) begin
            wdata = {e_known, (e_known && e_bel != 16'hffff) ? e_bel + 16'd1 : e_bel,
                     e_use, e_cap};
        end else if (i_cmd.item_wr) begin
            wdata = {n_known, n_bel, n_use, n_cap};
        end
    end

    sars_ram #(.WIDTH(sars_pkg::ENT_W), .DEPTH(sars_pkg::NODES)) u_tab (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_last_age <= '0;
        end else begin
            if (i_cmd.sweep_inc) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.age_chk && o_sts.age_due) begin
                r_last_age <= r_item.now_time;
            end
        end
    end

    always_comb begin
        o_sts.age_due = ({1'b0, r_last_age} + {1'b0, i_age_interval}
                        < {1'b0, r_item.now_time})
                        && r_item.kind != sars_pkg::K_OWN && r_item.kind != sars_pkg::K_SCORE;
        o_sts.sweep_last = (r_sweep == sars_pkg::ID_W'(sars_pkg::NODES - 1));
        o_sts.need_div = r_item.kind == sars_pkg::K_MERGE && e_known && r_sum != 0;
        o_sts.div_done = !r_dbusy;
        o_sts.emits = r_item.kind == sars_pkg::K_READ ||
                      (r_item.kind == sars_pkg::K_SCORE && r_item.path_end &&
                       r_item.final_candidate);
    end

    // merge products, two 16x16 multiplies
    assign prod_a = {16'd0, r_item.neighbor_belief} * {16'd0, e_use};
    assign prod_b = {16'd0, e_bel} * {16'd0, r_item.amount};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= {1'b0, prod_a} + {1'b0, prod_b};
            r_sum <= {1'b0, e_bel} + {1'b0, r_item.neighbor_belief};
        end
    end
    assign r_bsum = r_sum;

    // restoring divider, one quotient bit a cycle
    assign trial = {r_rem[32:0], r_quo[32]} - {17'd0, r_bsum};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt <= 6'd33;
            r_rem <= '0;
            r_quo <= r_num;
        end else if (r_dbusy) begin
            if (!trial[33]) begin
                r_rem <= trial[32:0];
                r_quo <= {r_quo[31:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_quo[32]};
                r_quo <= {r_quo[31:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 6'd1;
            if (r_dcnt == 6'd1) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    assign hello_use = (e_cap > r_item.amount) ? e_cap - r_item.amount : 16'd0;

    always_comb begin
        n_known = e_known;
        n_bel = e_bel;
        n_use = e_use;
        n_cap = e_cap;
        case (r_item.kind)
            sars_pkg::K_CAP: n_cap = r_item.amount;
            sars_pkg::K_HELLO: begin
                n_use = hello_use; n_bel = 16'd1; n_known = 1'b1;
            end
            sars_pkg::K_OWN: begin
                n_use = r_item.amount; n_bel = 16'd1; n_known = 1'b1;
            end
            sars_pkg::K_MERGE: begin
                if (e_known) begin
                    n_bel = r_sum[16:1];
                    if (r_sum != 0) begin
                        n_use = r_quo[15:0];
                    end
                end else begin
                    n_bel = (r_item.neighbor_belief == 16'hffff) ? 16'hffff
                            : r_item.neighbor_belief + 16'd1;
                    n_use = r_item.amount;
                    n_known = 1'b1;
                end
            end
            sars_pkg::K_COMMIT: begin
                if (!e_known) begin
                    n_bel = 16'd10; n_known = 1'b1;
                    n_use = 16'd1;
                end else begin
                    n_use = (e_use == 16'hffff) ? e_use : e_use + 16'd1;
                end
            end
            sars_pkg::K_RELEASE: begin
                if (e_use != 0) begin
                    n_use = e_use - 16'd1;
                end
            end
            sars_pkg::K_SCORE: begin
                if (!e_known) begin
                    n_bel = 16'd1; n_use = 16'd0; n_known = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign remain = $signed({2'b00, n_cap}) - $signed({2'b00, n_use});
    assign pmin_n = (remain < r_pmin) ? remain : r_pmin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmin <= 18'sd131071;
            r_best <= '0;
            r_bidx <= '0;
            r_ccnt <= '0;
        end else if (i_cmd.score && r_item.kind == sars_pkg::K_SCORE) begin
            if (!r_item.path_end) begin
                r_pmin <= pmin_n;
            end else begin
                r_pmin <= 18'sd131071;
                if (r_item.final_candidate) begin
                    r_best <= '0; r_bidx <= '0; r_ccnt <= '0;
                end else if (r_ccnt < (sars_pkg::CAND_W+1)'(sars_pkg::MAX_CAND)) begin
                    if (r_ccnt == 0 || pmin_n > r_best) begin
                        r_best <= pmin_n;
                        r_bidx <= r_ccnt[sars_pkg::CAND_W-1:0];
                    end
                    r_ccnt <= r_ccnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.score) begin
            r_fin_best <= r_best;
            r_fin_idx <= r_bidx;
            if (r_ccnt < (sars_pkg::CAND_W+1)'(sars_pkg::MAX_CAND) &&
                (r_ccnt == 0 || pmin_n > r_best)) begin
                r_fin_best <= pmin_n;
                r_fin_idx <= r_ccnt[sars_pkg::CAND_W-1:0];
            end
            r_ent_known <= n_known;
            r_ent_bel <= n_bel;
            r_ent_use <= n_use;
        end
    end

    always_comb begin
        o_res = '0;
        o_res.entry_known = r_ent_known;
        o_res.entry_belief = r_ent_bel;
        o_res.entry_usage = r_ent_use;
        o_res.is_score = (r_item.kind == sars_pkg::K_SCORE);
        if (r_item.kind == sars_pkg::K_SCORE) begin
            o_res.chosen_index = 4'(r_fin_idx);
            o_res.chosen_score = r_fin_best[16:0];
        end
    end
endmodule
